>>> hdl/tfps_pkg.sv
package tfps_pkg;

    localparam int FRAC_BITS = 16;
    localparam int SUM_WIDTH = 48;
    localparam int SUM_HALF  = SUM_WIDTH / 2;
    localparam int ACC_WIDTH = 96;

    localparam logic [1:0] KIND_POSE  = 2'd0;
    localparam logic [1:0] KIND_RANGE = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    localparam logic [2:0] REG_PROP_GAIN  = 3'd0;
    localparam logic [2:0] REG_INT_GAIN   = 3'd1;
    localparam logic [2:0] REG_DERIV_GAIN = 3'd2;
    localparam logic [2:0] REG_FWD_SPEED  = 3'd3;
    localparam logic [2:0] REG_LEFT_X     = 3'd4;
    localparam logic [2:0] REG_RIGHT_X    = 3'd5;
    localparam logic [2:0] REG_RADIUS     = 3'd6;
    localparam logic [2:0] REG_OBST_LIMIT = 3'd7;

    // multiply operand selector for the shared multiplier
    typedef enum logic [1:0] {
        MUL_DX  = 2'd0,
        MUL_DY  = 2'd1,
        MUL_PID = 2'd2
    } mul_sel_t;

    typedef struct packed {
        logic        start;
        logic [63:0] radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] root;
    } sqrt_rsp_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -66'sh0_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

>>> hdl/track_following_pid_steer.sv
// track following pid steering block
// input channel (s_valid/s_ready) carries one item: s_kind selects a pose
// update (s_pos_x, s_pos_y), a laser range sample (s_range_sample) or a
// control tick. pose and range items give no result and are taken while
// the block is idle, so they can follow each other back to back.
// a control tick gives one result item on the m_ channel: m_turn_rate,
// m_linear_speed, m_track_error and m_stopped.
// a free tick on an arc sends the x/y squares through one shared 33x33
// multiplier, the arc distance through a bit-serial square root of 32
// steps, then four pid products (the integral one in two halves) through
// the same multiplier. a free tick on a straight skips the squares and
// the root.
// a stopped tick (obstacle latch set) answers with zero speeds.
// s_ready is low while a tick is at work; a waiting result sits in the
// output register, so pose and range items still go in meanwhile, and a
// further tick waits in its last step until the receiver takes the result.
// reset (aresetn low, synchronous) loads the register defaults, clears the
// pose, the pid state and the obstacle latch; only reset clears the latch.
// configuration registers are written over the apb port at 4*index
module track_following_pid_steer
    import tfps_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_kind,
    input  logic signed [31:0] s_pos_x,
    input  logic signed [31:0] s_pos_y,
    input  logic [30:0]        s_range_sample,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_turn_rate,
    output logic signed [31:0] m_linear_speed,
    output logic signed [31:0] m_track_error,
    output logic               m_stopped,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_DECIDE= 10'b0000000010,
        ST_SQX   = 10'b0000000100,
        ST_SQY   = 10'b0000001000,
        ST_ROOT  = 10'b0000010000,
        ST_WAIT  = 10'b0000100000,
        ST_PID   = 10'b0001000000,
        ST_MULP  = 10'b0010000000,
        ST_SHIFT = 10'b0100000000,
        ST_OUT   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic signed [31:0] kp_reg, ki_reg, kd_reg, fwd_reg, lx_reg, rx_reg;
    logic [30:0]        rad_reg, lim_reg;
    logic               wr_en;

    // block state
    logic signed [31:0]          robot_x_reg, robot_y_reg, last_err_reg;
    logic signed [SUM_WIDTH-1:0] sum_reg;
    logic                        obst_reg;

    // working registers
    logic               arc_w;              // item goes through the arc path
    logic signed [32:0] cx_reg;             // arc centre
    logic signed [31:0] err_reg;
    logic signed [32:0] diff_reg;
    logic               neg_reg;
    logic [64:0]        sq_reg;             // sum of squares, bit 64 overflow
    logic [1:0]         step_reg;           // pid product index
    logic signed [ACC_WIDTH-1:0] acc_reg;
    logic signed [65:0]          mul_reg;   // product of last multiply
    logic               mul_valid_reg;
    logic               mul_hi_reg;         // product is the upper integral half
    logic               out_free;

    // output register
    logic               m_valid_reg;
    logic signed [31:0] turn_out_reg, speed_out_reg, err_out_reg;
    logic               stop_out_reg;

    // shared multiplier, one product per cycle, registered
    logic signed [32:0]          mul_a;
    logic signed [32:0]          mul_b;
    logic signed [65:0]          mul_p;
    logic signed [32:0]          dx;
    logic [64:0]                 sq_sum_w;
    sqrt_req_t                   sq_req;
    sqrt_rsp_t                   sq_rsp;

    assign dx = cx_reg - 33'(robot_x_reg);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SQX: begin
                mul_a = dx;
                mul_b = dx;
            end
            ST_SQY: begin
                mul_a = 33'(robot_y_reg);
                mul_b = 33'(robot_y_reg);
            end
            ST_MULP: begin
                case (step_reg)
                    2'd0: begin
                        mul_a = 33'(err_reg);
                        mul_b = 33'(kp_reg);
                    end
                    2'd1: begin
                        mul_a = 33'(sum_reg[SUM_HALF-1:0]);
                        mul_b = 33'(ki_reg);
                    end
                    2'd2: begin
                        mul_a = 33'($signed(sum_reg[SUM_WIDTH-1:SUM_HALF]));
                        mul_b = 33'(ki_reg);
                    end
                    default: begin
                        mul_a = diff_reg;
                        mul_b = 33'(kd_reg);
                    end
                endcase
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 66'(mul_a) * 66'(mul_b);

    // dx squared already held, y squared in the product register
    assign sq_sum_w        = sq_reg + {1'b0, mul_reg[63:0]};
    assign sq_req.start    = (state_reg == ST_ROOT);
    assign sq_req.radicand = sq_sum_w[63:0];

    tfps_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (sq_req),
        .rsp     (sq_rsp)
    );

    // combinational helpers for the error and pid step
    logic signed [65:0] arc_err_w;
    logic signed [31:0] str_err_w;
    logic signed [SUM_WIDTH:0] sum_try;
    logic signed [SUM_WIDTH-1:0] sum_sat;
    logic signed [SUM_WIDTH-1:0] smax, smin;
    logic signed [32:0] diff_w;
    logic signed [ACC_WIDTH-1:0] acc_fin;
    logic signed [ACC_WIDTH-1:0] shifted;

    assign arc_w = (robot_x_reg <= lx_reg) || (robot_x_reg >= rx_reg);
    assign arc_err_w = 66'(sq_rsp.root) - 66'(rad_reg);
    assign str_err_w = (robot_y_reg > 0)
        ? sat32(66'(rad_reg) - 66'(robot_y_reg))
        : sat32(-66'(rad_reg) - 66'(robot_y_reg));
    assign smax = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    assign smin = {1'b1, {(SUM_WIDTH-1){1'b0}}};
    assign sum_try = (SUM_WIDTH+1)'(sum_reg) + (SUM_WIDTH+1)'(err_reg);
    assign sum_sat = (sum_try > (SUM_WIDTH+1)'(smax)) ? smax
                   : (sum_try < (SUM_WIDTH+1)'(smin)) ? smin
                   : sum_try[SUM_WIDTH-1:0];
    assign diff_w  = 33'(err_reg) - 33'(last_err_reg);
    assign acc_fin = neg_reg ? -acc_reg : acc_reg;
    assign shifted = acc_fin >>> FRAC_BITS;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_valid && s_ready && s_kind == KIND_TICK) begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (obst_reg) state_next = ST_OUT;
                else if (arc_w) state_next = ST_SQX;
                else state_next = ST_PID;
            end
            ST_SQX:   state_next = ST_SQY;
            ST_SQY:   state_next = ST_ROOT;
            ST_ROOT:  state_next = ST_WAIT;
            ST_WAIT:  if (sq_rsp.done) state_next = ST_PID;
            ST_PID:   state_next = ST_MULP;
            ST_MULP:  if (step_reg == 2'd3) state_next = ST_SHIFT;
            ST_SHIFT: if (!mul_valid_reg) state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            kp_reg        <= 32'sd6554;
            ki_reg        <= '0;
            kd_reg        <= '0;
            fwd_reg       <= 32'sd65536;
            lx_reg        <= -32'sd393216;
            rx_reg        <= 32'sd393216;
            rad_reg       <= 31'd393216;
            lim_reg       <= 31'd19661;
            robot_x_reg   <= '0;
            robot_y_reg   <= '0;
            sum_reg       <= '0;
            last_err_reg  <= '0;
            obst_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
            mul_valid_reg <= 1'b0;
            mul_hi_reg    <= 1'b0;
            step_reg      <= '0;
        end else begin
            state_reg <= state_next;
            if (wr_en) begin
                case (paddr[4:2])
                    REG_PROP_GAIN:  kp_reg  <= pwdata;
                    REG_INT_GAIN:   ki_reg  <= pwdata;
                    REG_DERIV_GAIN: kd_reg  <= pwdata;
                    REG_FWD_SPEED:  fwd_reg <= pwdata;
                    REG_LEFT_X:     lx_reg  <= pwdata;
                    REG_RIGHT_X:    rx_reg  <= pwdata;
                    REG_RADIUS:     rad_reg <= pwdata[30:0];
                    REG_OBST_LIMIT: lim_reg <= pwdata[30:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (s_valid && s_ready) begin
                case (s_kind)
                    KIND_POSE: begin
                        robot_x_reg <= s_pos_x;
                        robot_y_reg <= s_pos_y;
                    end
                    KIND_RANGE: if (s_range_sample < lim_reg) obst_reg <= 1'b1;
                    default: ;
                endcase
            end
            mul_valid_reg <= (state_reg == ST_MULP);
            mul_hi_reg    <= (state_reg == ST_MULP) && (step_reg == 2'd2);
            case (state_reg)
                ST_PID: begin
                    sum_reg      <= sum_sat;
                    last_err_reg <= err_reg;
                    step_reg     <= '0;
                end
                ST_MULP: step_reg <= step_reg + 2'd1;
                default: ;
            endcase
        end
        // datapath registers
        mul_reg <= mul_p;
        case (state_reg)
            ST_IDLE: begin
                acc_reg <= '0;
            end
            ST_DECIDE: begin
                cx_reg  <= (robot_x_reg <= lx_reg) ? 33'(lx_reg) : 33'(rx_reg);
                neg_reg <= (robot_y_reg > 0) && (robot_x_reg >= lx_reg)
                           && (robot_x_reg <= rx_reg);
                err_reg <= str_err_w;
            end
            ST_SQY:  sq_reg <= {1'b0, mul_reg[63:0]};
            ST_ROOT: sq_reg <= sq_sum_w;
            ST_WAIT: if (sq_rsp.done) begin
                err_reg <= sq_reg[64] ? 32'sh7FFF_FFFF : sat32(arc_err_w);
            end
            ST_PID:  diff_reg <= diff_w;
            default: ;
        endcase
        if (mul_valid_reg) begin
            if (mul_hi_reg) acc_reg <= acc_reg + (ACC_WIDTH'(mul_reg) <<< SUM_HALF);
            else acc_reg <= acc_reg + ACC_WIDTH'(mul_reg);
        end
        if (state_reg == ST_OUT && out_free) begin
            if (obst_reg) begin
                turn_out_reg  <= '0;
                speed_out_reg <= '0;
                err_out_reg   <= '0;
                stop_out_reg  <= 1'b1;
            end else begin
                turn_out_reg  <= (shifted > 96'sh7FFF_FFFF) ? 32'sh7FFF_FFFF
                               : (shifted < -96'sh8000_0000) ? 32'sh8000_0000
                               : shifted[31:0];
                speed_out_reg <= fwd_reg;
                err_out_reg   <= err_reg;
                stop_out_reg  <= 1'b0;
            end
        end
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_turn_rate    = turn_out_reg;
    assign m_linear_speed = speed_out_reg;
    assign m_track_error  = err_out_reg;
    assign m_stopped      = stop_out_reg;
    assign pready         = 1'b1;

    always_comb begin
        case (paddr[4:2])
            REG_PROP_GAIN:  prdata = kp_reg;
            REG_INT_GAIN:   prdata = ki_reg;
            REG_DERIV_GAIN: prdata = kd_reg;
            REG_FWD_SPEED:  prdata = fwd_reg;
            REG_LEFT_X:     prdata = lx_reg;
            REG_RIGHT_X:    prdata = rx_reg;
            REG_RADIUS:     prdata = {1'b0, rad_reg};
            REG_OBST_LIMIT: prdata = {1'b0, lim_reg};
            default:        prdata = '0;
        endcase
    end

    // a stalled result stays put
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_turn_rate)
            && $stable(m_track_error))) else $error("result changed while stalled");
    // stopped results carry zero speeds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_stopped) |-> (m_turn_rate == 0 && m_linear_speed == 0))
        else $error("stopped result with motion");
    // obstacle latch is sticky
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(obst_reg) |-> obst_reg) else $error("obstacle latch cleared");

endmodule

>>> hdl/tfps_sqrt.sv
module tfps_sqrt
    import tfps_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  sqrt_req_t req,
    output sqrt_rsp_t rsp
);

    logic [63:0] op_reg, op_next;
    logic [63:0] res_reg, res_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [63:0] bitv;
    logic [63:0] trial;

    // one result bit per cycle, 32 steps
    assign bitv  = 64'd1 << {cnt_reg[4:0], 1'b0};
    assign trial = res_reg + bitv;

    always_comb begin
        op_next   = op_reg;
        res_next  = res_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            op_next   = req.radicand;
            res_next  = '0;
            cnt_next  = 6'd31;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (op_reg >= trial) begin
                op_next  = op_reg - trial;
                res_next = (res_reg >> 1) + bitv;
            end else begin
                res_next = res_reg >> 1;
            end
            if (cnt_reg == 6'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 6'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        op_reg  <= op_next;
        res_reg <= res_next;
    end

    assign rsp.done = done_reg;
    assign rsp.root = res_reg[31:0];

endmodule

>>> bench/tb_track_following_pid_steer.sv
`timescale 1ns / 1ps

module tb_track_following_pid_steer;
    import tfps_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 2000000;
    // allow a margin for settling after a free tick
    localparam int SETTLE_CYCLES = 80;

    typedef struct {
        logic signed [31:0] turn;
        logic signed [31:0] speed;
        logic signed [31:0] err;
        logic               stop;
    } steer_cmd_t;

    // predicts steering commands and holds the ones still owed by the block
    class steer_scoreboard;
        longint kp, ki, kd, fwd, lx, rx, rad, lim;
        longint px, py, esum, elast;
        bit latched;
        steer_cmd_t owed_q[$];
        int errors;

        function new();
            kp = 6554; ki = 0; kd = 0; fwd = 65536;
            lx = -393216; rx = 393216; rad = 393216; lim = 19661;
            px = 0; py = 0; esum = 0; elast = 0; latched = 0; errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                REG_PROP_GAIN:  kp  = longint'(signed'(v));
                REG_INT_GAIN:   ki  = longint'(signed'(v));
                REG_DERIV_GAIN: kd  = longint'(signed'(v));
                REG_FWD_SPEED:  fwd = longint'(signed'(v));
                REG_LEFT_X:     lx  = longint'(signed'(v));
                REG_RIGHT_X:    rx  = longint'(signed'(v));
                REG_RADIUS:     rad = longint'(v[30:0]);
                REG_OBST_LIMIT: lim = longint'(v[30:0]);
                default: ;
            endcase
        endfunction

        function longint clip32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint root64(logic [63:0] op);
            logic [63:0] res, bitv, o;
            o = op; res = 0; bitv = 64'h4000_0000_0000_0000;
            while (bitv > o) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (o >= res + bitv) begin
                    o = o - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            return longint'(res);
        endfunction

        function longint arc_dist(longint cx);
            longint d;
            logic [63:0] dx, dy;
            logic [64:0] s;
            d = cx - px;
            dx = d < 0 ? -d : d;
            dy = py < 0 ? -py : py;
            s = dx * dx + dy * dy;
            if (s[64]) return 64'sd2147483647;
            return clip32(root64(s[63:0]) - rad);
        endfunction

        function void note_item(logic [1:0] kind, logic signed [31:0] x,
                                logic signed [31:0] y, logic [30:0] r);
            longint e, diff, smax, smin;
            logic signed [127:0] a, b, c, ev, sv, dv, acc, sh;
            steer_cmd_t cmd;
            smax = (longint'(1) <<< (SUM_WIDTH - 1)) - 1;
            smin = -smax - 1;
            if (kind == KIND_POSE) begin
                px = x; py = y;
            end else if (kind == KIND_RANGE) begin
                if (longint'(r) < lim) latched = 1;
            end else if (kind == KIND_TICK) begin
                if (latched) begin
                    cmd = '{0, 0, 0, 1'b1};
                end else begin
                    if (px <= lx) e = arc_dist(lx);
                    else if (px >= rx) e = arc_dist(rx);
                    else if (py > 0) e = clip32(rad - py);
                    else e = clip32(-rad - py);
                    // integral saturates at the sum register width
                    if (e > 0 && esum > smax - e) esum = smax;
                    else if (e < 0 && esum < smin - e) esum = smin;
                    else esum = esum + e;
                    diff = e - elast;
                    elast = e;
                    a = kp; b = ki; c = kd; ev = e; sv = esum; dv = diff;
                    acc = a * ev + b * sv + c * dv;
                    // upper straight steers the other way
                    if (py > 0 && px >= lx && px <= rx) acc = -acc;
                    sh = acc >>> FRAC_BITS;
                    if (sh > $signed(128'h7FFF_FFFF)) sh = $signed(128'h7FFF_FFFF);
                    else if (sh < -$signed(128'h8000_0000)) sh = -$signed(128'h8000_0000);
                    cmd.turn = sh[31:0];
                    cmd.speed = fwd[31:0];
                    cmd.err = e[31:0];
                    cmd.stop = 1'b0;
                end
                owed_q.push_back(cmd);
            end
        endfunction

        task report(string msg);
            $display("mismatch @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(steer_cmd_t got);
            steer_cmd_t want;
            if (owed_q.size() == 0) begin
                report("steering item with nothing owed");
                return;
            end
            want = owed_q.pop_front();
            if (got.turn !== want.turn)
                report($sformatf("turn_rate %0d, want %0d", got.turn, want.turn));
            if (got.speed !== want.speed)
                report($sformatf("linear_speed %0d, want %0d", got.speed, want.speed));
            if (got.err !== want.err)
                report($sformatf("track_error %0d, want %0d", got.err, want.err));
            if (got.stop !== want.stop)
                report($sformatf("stopped %0b, want %0b", got.stop, want.stop));
        endtask
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    logic [1:0] s_kind = KIND_POSE;
    logic signed [31:0] s_pos_x = 0;
    logic signed [31:0] s_pos_y = 0;
    logic [30:0] s_range_sample = 0;
    logic m_valid;
    logic m_ready = 0;
    logic signed [31:0] m_turn_rate, m_linear_speed, m_track_error;
    logic m_stopped;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [4:0] paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic pready;

    steer_scoreboard steer_sb;
    int cycles = 0;
    bit calm = 0;  // phase with no idling on either side

    always #2 aclk = ~aclk;

    track_following_pid_steer dut (.*);

    // mostly short gaps, a few long ones
    function int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side: sample at the rising edge, change ready at the falling one
    initial begin
        int stall;
        steer_cmd_t got;
        stall = 0;
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                m_ready = 0;
                stall--;
            end else begin
                m_ready = 1;
            end
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got = '{m_turn_rate, m_linear_speed, m_track_error, m_stopped};
                steer_sb.check_result(got);
                stall = pick_gap();
            end
        end
    end

    task send_item(logic [1:0] kind, logic signed [31:0] x, logic signed [31:0] y,
                   logic [30:0] r);
        int gap;
        gap = pick_gap();
        repeat (gap) @(negedge aclk);
        s_valid = 1; s_kind = kind; s_pos_x = x; s_pos_y = y; s_range_sample = r;
        do @(posedge aclk); while (!s_ready);
        steer_sb.note_item(kind, x, y, r);
        @(negedge aclk);
        s_valid = 0;
    endtask

    task pose(logic signed [31:0] x, logic signed [31:0] y);
        send_item(KIND_POSE, x, y, 31'($urandom));
    endtask

    task tick();
        send_item(KIND_TICK, $urandom, $urandom, 31'($urandom));
    endtask

    // idle until every owed item is back and the block has settled
    task drain();
        while (steer_sb.owed_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task reg_write(logic [2:0] idx, logic [31:0] v);
        psel = 1; pwrite = 1; penable = 0; paddr = {idx, 2'b00}; pwdata = v;
        @(negedge aclk);
        penable = 1;
        @(posedge aclk);
        steer_sb.set_reg(idx, v);
        @(negedge aclk);
        psel = 0; penable = 0; pwrite = 0;
    endtask

    task load_setting(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
                      logic [31:0] fwd, logic [31:0] lx, logic [31:0] rx,
                      logic [31:0] rad, logic [31:0] lim);
        drain();
        reg_write(REG_PROP_GAIN, kp);
        reg_write(REG_INT_GAIN, ki);
        reg_write(REG_DERIV_GAIN, kd);
        reg_write(REG_FWD_SPEED, fwd);
        reg_write(REG_LEFT_X, lx);
        reg_write(REG_RIGHT_X, rx);
        reg_write(REG_RADIUS, rad);
        reg_write(REG_OBST_LIMIT, lim);
    endtask

    // random traffic; range samples stay at or above the limit so the
    // latch only sets when the caller allows it
    task random_items(int n, bit allow_latch);
        int k;
        logic signed [31:0] x, y;
        logic [30:0] r;
        repeat (n) begin
            k = $urandom_range(99);
            if (k < 38) begin
                case ($urandom_range(3))
                    0: begin x = $urandom; y = $urandom; end
                    1: begin
                        x = $urandom_range(1) ? steer_sb.lx[31:0] : steer_sb.rx[31:0];
                        x = x + int'($urandom_range(0, 8)) - 4;
                        y = int'($urandom_range(0, 2621440)) - 1310720;
                    end
                    default: begin
                        x = int'($urandom_range(0, 2621440)) - 1310720;
                        y = int'($urandom_range(0, 2621440)) - 1310720;
                    end
                endcase
                pose(x, y);
            end else if (k < 60) begin
                if (allow_latch)
                    r = 31'($urandom);
                else
                    r = 31'(steer_sb.lim + ($urandom % (32'h8000_0000 - steer_sb.lim)));
                send_item(KIND_RANGE, $urandom, $urandom, r);
            end else if (k < 96) begin
                tick();
            end else begin
                send_item(KIND_UNUSED, $urandom, $urandom, 31'($urandom));
            end
        end
    endtask

    initial begin
        steer_sb = new();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // reset setting: lower and upper straights, both arcs, boundaries
        tick();
        pose(0, 3 * 65536); tick();
        pose(-393216, 393216); tick();
        pose(393216, -1); tick();
        pose(-655360, 0); tick();
        pose(32'sh8000_0000, 32'sh8000_0000); tick();
        pose(32'sh7FFF_FFFF, 32'sh7FFF_FFFF); tick();
        pose(0, 32'sh8000_0000); tick();
        pose(0, -393216); tick();
        send_item(KIND_UNUSED, 5, 7, 31'd0);
        send_item(KIND_RANGE, 0, 0, 31'd19661);
        send_item(KIND_RANGE, 0, 0, 31'h7FFF_FFFF);
        tick();
        random_items(180, 0);

        // moderate gains, every register written
        calm = 1;
        load_setting(32'd32768, 32'd655, 32'd13107, 32'd98304,
                     -32'sd655360, 32'd655360, 32'd196608, 32'd0);
        random_items(200, 0);
        calm = 0;

        // extremes, centres in the wrong order: arc sum overflows
        load_setting(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                     32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0);
        pose(32'sh8000_0000, 32'sh8000_0000); tick();
        pose(32'sh7FFF_FFFF, 32'sh7FFF_FFFF); tick();
        pose(0, 1); tick();
        random_items(200, 0);

        load_setting(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'h0000_0100);
        pose(32'sh8000_0000, 0); tick();
        pose(0, 1); tick();
        random_items(200, 0);

        load_setting($urandom, $urandom_range(0, 2000), $urandom, $urandom,
                     -int'($urandom_range(0, 655360)), $urandom_range(0, 655360),
                     $urandom_range(0, 655360), $urandom_range(0, 1000));
        random_items(200, 0);

        // latch the obstacle; every tick from here on is stopped
        load_setting($urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, 32'h7FFF_FFFF);
        send_item(KIND_RANGE, 0, 0, 31'd0);
        tick();
        random_items(40, 1);

        drain();
        if (steer_sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
